[rtl/timer_queue_scheduler_macros.svh]
// Assertion macros for the timer queue scheduler.
// Used by the top level only; no other dependencies.
`ifndef TIMER_QUEUE_SCHEDULER_MACROS_SVH
`define TIMER_QUEUE_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define TQS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TQS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TQS_ASSERT(label, prop)
`define TQS_ASSERT_RST(label, prop)
`endif
`endif

[rtl/tqs_pkg.sv]
// Package for the timer queue scheduler: operation codes, result kinds,
// payload structs, sequencer states and small helper functions. No dependencies.
package tqs_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int TICK_W      = 48;
  localparam int MAX_FIRE    = 16;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_PAUSE   = 3'd2;
  localparam logic [2:0] OP_UNPAUSE = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;
  localparam logic [2:0] OP_ADVANCE = 3'd5;
  localparam logic [2:0] OP_RESET   = 3'd6;

  localparam logic [1:0] EV_CMD   = 2'd0;
  localparam logic [1:0] EV_QUERY = 2'd1;
  localparam logic [1:0] EV_FIRED = 2'd2;
  localparam logic [1:0] EV_IDLE  = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    logic        next_frame;
    logic [3:0]  handle_slot;
    logic [31:0] handle_generation;
    logic [31:0] delta_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic        success;
    logic [3:0]  out_slot;
    logic [31:0] out_generation;
    logic        is_active;
    logic        is_paused;
    logic [31:0] remaining_ticks;
    logic        last;
  } out_item_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [31:0]       generation;
    logic [TICK_W-1:0] deadline;
    logic [31:0]       period;
    logic [31:0]       remainder;
  } slot_rec_t;

  // Request from the sequencer to the modulo unit.
  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [31:0]       divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } mod_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_SCAN_RD, ST_SCAN, ST_PICK_RD, ST_PICK,
    ST_MOD, ST_REARM, ST_OUT
  } state_t;

  function automatic logic [TICK_W-1:0] sat_add(logic [TICK_W-1:0] a, logic [31:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {{(TICK_W-31){1'b0}}, b};
    return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
  endfunction

  function automatic logic [31:0] time_left(logic [TICK_W-1:0] dl, logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] d;
    d = (dl > now) ? dl - now : '0;
    return (|d[TICK_W-1:32]) ? 32'hFFFF_FFFF : d[31:0];
  endfunction
endpackage

[rtl/tqs_stream_if.sv]
// Valid/ready channel interface for the timer queue scheduler.
// Depends on tqs_pkg for nothing; payload type is a parameter.
interface tqs_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/timer_queue_scheduler.sv]
// Timer queue scheduler top level: command sequencer around a slot memory.
// A command result is offered after the ST_READ and ST_EXEC states; the next
// command is accepted only once the result has been taken and the sequencer is
// back in ST_IDLE. An advance scans the whole table once per firing, with a
// serial modulo for a periodic timer; one item at a time.
// Synchronous active-low reset clears time, counters and flag bits; the slot
// memory and free stack hold no reset and are read only after being written.
`include "timer_queue_scheduler_macros.svh"
module timer_queue_scheduler (
  input logic clk,
  input logic rst_n,
  tqs_stream_if.sink   in_ch,
  tqs_stream_if.source out_ch
);
  import tqs_pkg::*;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  // The output register holds a firing that has not been offered yet.
  logic held_r, held_nxt;

  logic [TICK_W-1:0] now_r, now_nxt;
  logic [31:0] gen_cnt_r, gen_cnt_nxt;
  logic [NUM_SLOTS-1:0] live_r, live_nxt, paused_r, paused_nxt, nf_r, nf_nxt;
  // Slots already fired in this advance.
  logic [NUM_SLOTS-1:0] done_r, done_nxt;
  logic [SLOT_W-1:0] stack_r [NUM_SLOTS];
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt, used_r, used_nxt;
  logic push, pop;
  logic [SLOT_W-1:0] push_slot;

  // Scan and pick bookkeeping.
  logic [SLOT_W-1:0] idx_r, idx_nxt, best_r, best_nxt;
  logic have_r, have_nxt;
  logic [TICK_W-1:0] best_dl_r, best_dl_nxt;
  logic [31:0] best_gen_r, best_gen_nxt;
  logic [CNT_W-1:0] fired_r, fired_nxt;
  slot_rec_t cur_r, cur_nxt;

  logic we;
  logic [SLOT_W-1:0] waddr, raddr;
  slot_rec_t wdata, rdata;
  mod_req_t mreq;
  mod_rsp_t mrsp;

  tqs_slot_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  tqs_mod_unit u_mod (.clk, .rst_n, .req(mreq), .rsp(mrsp));

  logic valid_h;
  logic [SLOT_W-1:0] hs;
  logic due;
  logic [TICK_W-1:0] late;

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = res_r;
  assign hs = item_r.handle_slot;

  always_comb begin
    state_nxt = state_r; item_nxt = item_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    held_nxt = held_r;
    now_nxt = now_r; gen_cnt_nxt = gen_cnt_r;
    live_nxt = live_r; paused_nxt = paused_r; nf_nxt = nf_r; done_nxt = done_r;
    free_cnt_nxt = free_cnt_r; used_nxt = used_r;
    push = 1'b0; pop = 1'b0; push_slot = '0;
    idx_nxt = idx_r; best_nxt = best_r; have_nxt = have_r;
    best_dl_nxt = best_dl_r; best_gen_nxt = best_gen_r; fired_nxt = fired_r;
    cur_nxt = cur_r;
    we = 1'b0; waddr = hs; wdata = cur_r; raddr = hs;
    mreq = '{start: 1'b0, dividend: '0, divisor: cur_r.period};
    valid_h = 1'b0; due = 1'b0; late = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_nxt = in_ch.payload;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // Read address stable: the handle slot; an advance starts its scan at index 0.
        raddr = hs;
        if (item_r.operation == OP_ADVANCE) begin
          now_nxt = sat_add(now_r, item_r.delta_ticks);
          done_nxt = '0; fired_nxt = '0;
          state_nxt = ST_PICK_RD;
        end else begin
          state_nxt = ST_EXEC;
        end
        idx_nxt = '0; have_nxt = 1'b0; held_nxt = 1'b0;
      end
      ST_EXEC: begin
        res_nxt = '0; res_nxt.last = 1'b1; res_nxt.event_kind = EV_CMD;
        valid_h = (item_r.handle_generation != '0) && ({1'b0, hs} < used_r) &&
                  live_r[hs] && (rdata.generation == item_r.handle_generation);
        cur_nxt = rdata;
        unique case (item_r.operation)
          OP_ADD: begin
            if (free_cnt_r != '0 || used_r != CNT_W'(NUM_SLOTS)) begin
              if (free_cnt_r != '0) begin
                waddr = stack_r[SLOT_W'(free_cnt_r - 1'b1)];
                pop = 1'b1;
              end else begin
                waddr = used_r[SLOT_W-1:0];
                used_nxt = used_r + 1'b1;
              end
              gen_cnt_nxt = (gen_cnt_r == 32'hFFFF_FFFF) ? 32'd1 : gen_cnt_r + 1'b1;
              we = 1'b1;
              wdata = '{generation: gen_cnt_nxt,
                        deadline: sat_add(now_r, item_r.delay_ticks),
                        period: item_r.period_ticks, remainder: '0};
              live_nxt[waddr] = 1'b1; paused_nxt[waddr] = 1'b0;
              nf_nxt[waddr] = item_r.next_frame;
              res_nxt.success = 1'b1; res_nxt.out_slot = waddr;
              res_nxt.out_generation = gen_cnt_nxt;
            end
          end
          OP_CLEAR: begin
            if (valid_h) begin
              live_nxt[hs] = 1'b0; paused_nxt[hs] = 1'b0; nf_nxt[hs] = 1'b0;
              push = 1'b1; push_slot = hs;
            end
            res_nxt.success = valid_h;
          end
          OP_PAUSE: begin
            if (valid_h && !paused_r[hs]) begin
              we = 1'b1; wdata = rdata;
              wdata.remainder = time_left(rdata.deadline, now_r);
              paused_nxt[hs] = 1'b1; res_nxt.success = 1'b1;
            end
          end
          OP_UNPAUSE: begin
            if (valid_h && paused_r[hs]) begin
              we = 1'b1; wdata = rdata;
              wdata.deadline = sat_add(now_r, rdata.remainder);
              paused_nxt[hs] = 1'b0; res_nxt.success = 1'b1;
            end
          end
          OP_QUERY: begin
            res_nxt.event_kind = EV_QUERY;
            res_nxt.success = valid_h; res_nxt.is_active = valid_h;
            if (valid_h) begin
              res_nxt.is_paused = paused_r[hs];
              res_nxt.remaining_ticks = nf_r[hs] ? '0 :
                paused_r[hs] ? rdata.remainder : time_left(rdata.deadline, now_r);
            end
          end
          OP_RESET: begin
            live_nxt = '0; paused_nxt = '0; nf_nxt = '0;
            free_cnt_nxt = '0; used_nxt = '0; now_nxt = '0;
            res_nxt.success = 1'b1;
          end
          default: ;
        endcase
        out_valid_nxt = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_PICK_RD: begin
        // Read one slot of the scan for the earliest due slot not yet fired.
        raddr = idx_r;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        raddr = idx_r;
        due = ({1'b0, idx_r} < used_r) && live_r[idx_r] && !paused_r[idx_r] &&
              !done_r[idx_r] && (nf_r[idx_r] || rdata.deadline <= now_r);
        if (due && (!have_r || rdata.deadline < best_dl_r ||
            (rdata.deadline == best_dl_r && rdata.generation < best_gen_r))) begin
          have_nxt = 1'b1; best_nxt = idx_r;
          best_dl_nxt = rdata.deadline; best_gen_nxt = rdata.generation;
          cur_nxt = rdata;
        end
        if (idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_SCAN;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_PICK_RD;
        end
      end
      ST_SCAN: begin
        if (!have_r) begin
          if (fired_r == '0) begin
            res_nxt = '0; res_nxt.event_kind = EV_IDLE; res_nxt.success = 1'b1;
            res_nxt.last = 1'b1; out_valid_nxt = 1'b1;
          end else begin
            // Mark the previous firing as last: it is still held in res_r.
            res_nxt.last = 1'b1; out_valid_nxt = 1'b1; held_nxt = 1'b0;
          end
          state_nxt = ST_OUT;
        end else begin
          done_nxt[best_r] = 1'b1;
          late = (now_r > cur_r.deadline) ? now_r - cur_r.deadline : '0;
          if (nf_r[best_r] && cur_r.period == '0) begin
            state_nxt = ST_REARM;
          end else if (cur_r.period != '0) begin
            mreq.start = 1'b1; mreq.dividend = late; state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_REARM;
          end
        end
      end
      ST_MOD: begin
        if (mrsp.done) begin
          we = 1'b1; waddr = best_r; wdata = cur_r;
          wdata.deadline = sat_add(now_r, cur_r.period - mrsp.remainder);
          state_nxt = ST_REARM;
        end
      end
      ST_REARM: begin
        if (cur_r.period == '0) begin
          live_nxt[best_r] = 1'b0; paused_nxt[best_r] = 1'b0; nf_nxt[best_r] = 1'b0;
          push = 1'b1; push_slot = best_r;
        end
        // Firing result held back until the next pick decides "last".
        state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (held_r) begin
          // Another firing follows, so the held one is offered as not last.
          out_valid_nxt = 1'b1; held_nxt = 1'b0;
        end else if (!out_valid_r || out_ch.ready) begin
          res_nxt = '0; res_nxt.event_kind = EV_FIRED; res_nxt.success = 1'b1;
          res_nxt.out_slot = best_r; res_nxt.out_generation = cur_r.generation;
          res_nxt.last = (fired_r == CNT_W'(MAX_FIRE - 1));
          fired_nxt = fired_r + 1'b1;
          idx_nxt = '0; have_nxt = 1'b0;
          if (fired_r == CNT_W'(MAX_FIRE - 1)) begin
            out_valid_nxt = 1'b1; state_nxt = ST_OUT;
          end else begin
            held_nxt = 1'b1; state_nxt = ST_PICK_RD;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (push) begin
      free_cnt_nxt = free_cnt_r + 1'b1;
    end else if (pop) begin
      free_cnt_nxt = free_cnt_r - 1'b1;
    end
  end

  // In ST_SCAN_RD the output register may still hold the previous firing
  // that is waiting to be marked; it is shown only once the next is known.
  always_ff @(posedge clk) begin
    item_r <= item_nxt; res_r <= res_nxt; cur_r <= cur_nxt;
    idx_r <= idx_nxt; best_r <= best_nxt; best_dl_r <= best_dl_nxt;
    best_gen_r <= best_gen_nxt;
    if (push) begin
      stack_r[free_cnt_r[SLOT_W-1:0]] <= push_slot;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE; out_valid_r <= 1'b0; now_r <= '0; gen_cnt_r <= '0;
      live_r <= '0; paused_r <= '0; nf_r <= '0; done_r <= '0;
      free_cnt_r <= '0; used_r <= '0; have_r <= 1'b0; fired_r <= '0;
      held_r <= 1'b0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt; now_r <= now_nxt;
      gen_cnt_r <= gen_cnt_nxt; live_r <= live_nxt; paused_r <= paused_nxt;
      nf_r <= nf_nxt; done_r <= done_nxt; free_cnt_r <= free_cnt_nxt;
      used_r <= used_nxt; have_r <= have_nxt; fired_r <= fired_nxt;
      held_r <= held_nxt;
    end
  end

  `TQS_ASSERT(a_free_bound, (free_cnt_r <= used_r))
  `TQS_ASSERT(a_paused_live, ((paused_r & ~live_r) == '0))
  `TQS_ASSERT(a_no_accept_busy, (in_ch.valid && in_ch.ready |=> state_r == ST_READ))
  `TQS_ASSERT_RST(a_reset_idle, (!rst_n |=> !out_valid_r))
endmodule

[rtl/tqs_mod_unit.sv]
// Restoring bit-serial remainder unit: 48-bit dividend modulo 32-bit divisor.
// Depends on tqs_pkg.
module tqs_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tqs_pkg::mod_req_t req,
  output tqs_pkg::mod_rsp_t rsp
);
  import tqs_pkg::*;

  logic [TICK_W-1:0] dvd_r, dvd_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       dvs_r, dvs_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [32:0]       trial;

  always_comb begin
    dvd_nxt = dvd_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, dvd_r[TICK_W-1]};
    if (req.start) begin
      dvd_nxt = req.dividend; dvs_nxt = req.divisor; rem_nxt = '0;
      cnt_nxt = 6'(TICK_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = (trial >= {1'b0, dvs_r}) ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.remainder = rem_r;
endmodule

[rtl/tqs_slot_ram.sv]
// Slot record memory: one write port, one read port, registered read data.
// Depends on tqs_pkg.
module tqs_slot_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tqs_pkg::SLOT_W-1:0] waddr,
  input  tqs_pkg::slot_rec_t         wdata,
  input  logic [tqs_pkg::SLOT_W-1:0] raddr,
  output tqs_pkg::slot_rec_t         rdata
);
  import tqs_pkg::*;
  slot_rec_t mem [NUM_SLOTS];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[bench/timer_queue_scheduler_test.sv]
// Self-checking bench for timer_queue_scheduler: a clocked driver and monitor
// around the block, with a behavioral predictor of the timer table.
// Depends on tqs_pkg, tqs_stream_if and the RTL top level.
module timer_queue_scheduler_test;
  import tqs_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  tqs_stream_if #(.payload_t(in_item_t))  in_ch (clk);
  tqs_stream_if #(.payload_t(out_item_t)) out_ch (clk);

  timer_queue_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state: a private copy of the timer table.
  logic [TICK_W-1:0] now_t;
  logic [31:0]       gen_ctr;
  logic              t_live [NUM_SLOTS];
  logic              t_paused [NUM_SLOTS];
  logic              t_nf [NUM_SLOTS];
  logic [31:0]       t_gen [NUM_SLOTS];
  logic [TICK_W-1:0] t_dl [NUM_SLOTS];
  logic [31:0]       t_per [NUM_SLOTS];
  logic [31:0]       t_rem [NUM_SLOTS];
  logic [3:0]        free_lifo [NUM_SLOTS];
  int                free_n;
  int                used_n;

  in_item_t  pending_cmds [$];
  out_item_t expected_events [$];

  // Handles the stimulus has seen, so that commands can aim at live timers.
  logic [3:0]  known_slot [$];
  logic [31:0] known_gen [$];

  int  mismatches;
  bit  failed;
  bit  quiet;          // no idling in the last part of the run
  bit  hold_rx;        // long receiver hold-off request
  int  idle_cycles;

  function automatic logic [TICK_W-1:0] add_sat(logic [TICK_W-1:0] a, logic [31:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + (TICK_W + 1)'(b);
    return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
  endfunction

  function automatic logic [31:0] ticks_left(int s);
    logic [TICK_W-1:0] d;
    d = (t_dl[s] > now_t) ? t_dl[s] - now_t : '0;
    return (d > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  function automatic int find_timer(logic [3:0] slot, logic [31:0] g);
    if (g == 0 || int'(slot) >= used_n) return -1;
    if (!t_live[slot] || t_gen[slot] != g) return -1;
    return int'(slot);
  endfunction

  function automatic void drop_timer(int s);
    t_live[s] = 1'b0;
    t_paused[s] = 1'b0;
    t_nf[s] = 1'b0;
    if (free_n < NUM_SLOTS) begin
      free_lifo[free_n] = 4'(s);
      free_n++;
    end
  endfunction

  function automatic bit earlier(int a, int b);
    if (t_dl[a] != t_dl[b]) return t_dl[a] < t_dl[b];
    if (t_gen[a] != t_gen[b]) return t_gen[a] < t_gen[b];
    return a < b;
  endfunction

  function automatic void push_event(logic [1:0] kind, logic ok, logic [3:0] slot,
                                     logic [31:0] g, logic act, logic pau,
                                     logic [31:0] rem, logic fin);
    out_item_t e;
    e.event_kind = kind;
    e.success = ok;
    e.out_slot = slot;
    e.out_generation = g;
    e.is_active = act;
    e.is_paused = pau;
    e.remaining_ticks = rem;
    e.last = fin;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void queue_cmd(in_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void predictor_reset();
    now_t = '0;
    gen_ctr = '0;
    free_n = 0;
    used_n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      t_live[i] = 1'b0;
      t_paused[i] = 1'b0;
      t_nf[i] = 1'b0;
    end
  endfunction

  // Works out the events one accepted command causes and updates the table.
  function automatic void predict_events(in_item_t c);
    int s;
    int due [$];
    int fired;
    int v;
    int j;
    logic [TICK_W-1:0] late;
    logic [TICK_W-1:0] step;
    case (c.operation)
      OP_ADD: begin
        s = -1;
        if (free_n > 0) begin
          free_n--;
          s = int'(free_lifo[free_n]);
        end else if (used_n < NUM_SLOTS) begin
          s = used_n;
          used_n++;
        end
        if (s < 0) begin
          push_event(EV_CMD, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          gen_ctr = (gen_ctr == 32'hFFFF_FFFF) ? 32'd1 : gen_ctr + 1;
          t_live[s] = 1'b1;
          t_paused[s] = 1'b0;
          t_nf[s] = c.next_frame;
          t_gen[s] = gen_ctr;
          t_dl[s] = add_sat(now_t, c.delay_ticks);
          t_per[s] = c.period_ticks;
          t_rem[s] = '0;
          push_event(EV_CMD, 1, 4'(s), gen_ctr, 0, 0, 0, 1);
        end
      end
      OP_CLEAR: begin
        s = find_timer(c.handle_slot, c.handle_generation);
        if (s >= 0) drop_timer(s);
        push_event(EV_CMD, s >= 0, 0, 0, 0, 0, 0, 1);
      end
      OP_PAUSE: begin
        s = find_timer(c.handle_slot, c.handle_generation);
        if (s >= 0 && !t_paused[s]) begin
          t_rem[s] = ticks_left(s);
          t_paused[s] = 1'b1;
          push_event(EV_CMD, 1, 0, 0, 0, 0, 0, 1);
        end else begin
          push_event(EV_CMD, 0, 0, 0, 0, 0, 0, 1);
        end
      end
      OP_UNPAUSE: begin
        s = find_timer(c.handle_slot, c.handle_generation);
        if (s >= 0 && t_paused[s]) begin
          t_dl[s] = add_sat(now_t, t_rem[s]);
          t_paused[s] = 1'b0;
          push_event(EV_CMD, 1, 0, 0, 0, 0, 0, 1);
        end else begin
          push_event(EV_CMD, 0, 0, 0, 0, 0, 0, 1);
        end
      end
      OP_QUERY: begin
        s = find_timer(c.handle_slot, c.handle_generation);
        if (s < 0) begin
          push_event(EV_QUERY, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          push_event(EV_QUERY, 1, 0, 0, 1, t_paused[s],
                     t_nf[s] ? 32'd0 : (t_paused[s] ? t_rem[s] : ticks_left(s)), 1);
        end
      end
      OP_ADVANCE: begin
        now_t = add_sat(now_t, c.delta_ticks);
        for (int i = 0; i < used_n; i++) begin
          if (t_live[i] && !t_paused[i] && (t_nf[i] || t_dl[i] <= now_t)) begin
            // Insertion keeps the list in firing order.
            j = 0;
            while (j < due.size() && !earlier(i, due[j])) j++;
            due.insert(j, i);
          end
        end
        fired = (due.size() > MAX_FIRE) ? MAX_FIRE : due.size();
        if (fired == 0) push_event(EV_IDLE, 1, 0, 0, 0, 0, 0, 1);
        for (int k = 0; k < fired; k++) begin
          v = due[k];
          push_event(EV_FIRED, 1, 4'(v), t_gen[v], 0, 0, 0, k == fired - 1);
          if (t_per[v] != 0) begin
            late = (now_t > t_dl[v]) ? now_t - t_dl[v] : '0;
            step = TICK_W'(t_per[v]) - (late % TICK_W'(t_per[v]));
            t_dl[v] = add_sat(now_t, step[31:0]);
          end else begin
            drop_timer(v);
          end
        end
      end
      OP_RESET: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          t_live[i] = 1'b0;
          t_paused[i] = 1'b0;
          t_nf[i] = 1'b0;
        end
        free_n = 0;
        used_n = 0;
        now_t = '0;
        push_event(EV_CMD, 1, 0, 0, 0, 0, 0, 1);
      end
      default: push_event(EV_CMD, 0, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------
  function automatic in_item_t blank_cmd(logic [2:0] op);
    in_item_t c;
    c = '0;
    c.operation = op;
    // Unused fields carry noise so that every bit toggles.
    c.delay_ticks = $urandom();
    c.period_ticks = $urandom();
    c.handle_slot = 4'($urandom());
    c.handle_generation = $urandom();
    c.delta_ticks = $urandom();
    return c;
  endfunction

  function automatic void queue_add(logic [31:0] dly, logic [31:0] per, logic nf);
    in_item_t c;
    c = blank_cmd(OP_ADD);
    c.delay_ticks = dly;
    c.period_ticks = per;
    c.next_frame = nf;
    queue_cmd(c);
  endfunction

  function automatic void queue_handle_op(logic [2:0] op, logic [3:0] slot,
                                          logic [31:0] g);
    in_item_t c;
    c = blank_cmd(op);
    c.handle_slot = slot;
    c.handle_generation = g;
    queue_cmd(c);
  endfunction

  function automatic void queue_advance(logic [31:0] d);
    in_item_t c;
    c = blank_cmd(OP_ADVANCE);
    c.delta_ticks = d;
    queue_cmd(c);
  endfunction

  // Random delays favor short values so that timers actually fire.
  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      default: return 32'($urandom_range(1, 60));
    endcase
  endfunction

  // A handle op aims at a recent live-looking handle most of the time.
  function automatic void random_item();
    int k;
    logic [3:0]  hs;
    logic [31:0] hg;
    k = $urandom_range(0, 99);
    hs = 4'($urandom());
    hg = $urandom();
    if (known_slot.size() > 0 && $urandom_range(0, 9) < 8) begin
      int idx;
      idx = $urandom_range(0, known_slot.size() - 1);
      hs = known_slot[idx];
      hg = known_gen[idx];
      if ($urandom_range(0, 19) == 0) hg = 0;
    end
    if (k < 30) queue_add(pick_ticks(), ($urandom_range(0, 2) == 0) ? 32'd0 : pick_ticks(),
                          $urandom_range(0, 5) == 0);
    else if (k < 38) queue_handle_op(OP_CLEAR, hs, hg);
    else if (k < 46) queue_handle_op(OP_PAUSE, hs, hg);
    else if (k < 54) queue_handle_op(OP_UNPAUSE, hs, hg);
    else if (k < 64) queue_handle_op(OP_QUERY, hs, hg);
    else if (k < 96) queue_advance(pick_ticks());
    else if (k < 98) queue_cmd(blank_cmd(OP_RESET));
    else queue_cmd(blank_cmd(3'd7));
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers the head of the pending queue, with random gaps.
  // ---------------------------------------------------------------------
  int  tx_gap;
  bit  tx_wait_drain;
  int  accepted_cmds;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
      tx_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_events(in_ch.payload);
        accepted_cmds <= accepted_cmds + 1;
        pending_cmds.delete(0);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current offer until it is taken.
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (tx_wait_drain && expected_events.size() > 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
        tx_gap <= $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_cmds[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver hold-off counter, kept in a process of its own.
  // ---------------------------------------------------------------------
  int hold_cnt;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_rx && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest expectation.
  // ---------------------------------------------------------------------
  int rx_gap;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
        if (expected_events.size() == 0) begin
          failed <= 1'b1;
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result transfer: %p", out_ch.payload);
        end else begin
          want = expected_events[0];
          expected_events.delete(0);
          if (out_ch.payload !== want) begin
            failed <= 1'b1;
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %p, got %p", want, out_ch.payload);
          end
          if (out_ch.payload.event_kind == EV_CMD && out_ch.payload.success &&
              want.out_generation != 0) begin
            known_slot.insert(known_slot.size(), want.out_slot);
            known_gen.insert(known_gen.size(), want.out_generation);
            if (known_slot.size() > 24) begin
              known_slot.delete(0);
              known_gen.delete(0);
            end
          end
        end
      end else if (in_ch.valid && in_ch.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // Receiver pacing: a long hold-off on request, else random short bursts.
      if (hold_rx && hold_cnt < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        rx_gap <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // The watchdog ends the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_events.size() > 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    failed = 1'b0;
    quiet = 1'b0;
    hold_rx = 1'b0;
    idle_cycles = 0;
    tx_wait_drain = 1'b0;
    accepted_cmds = 0;
    predictor_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: handle checks, extremes, pause and next-frame cases.
    queue_handle_op(OP_QUERY, 4'd0, 32'd0);       // zero generation, empty table
    queue_add(32'd0, 32'd0, 1'b0);                // due at once, one-shot
    queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // next-frame with the largest period
    queue_add(32'd10, 32'd3, 1'b0);
    queue_handle_op(OP_QUERY, 4'd1, 32'd2);
    queue_handle_op(OP_QUERY, 4'd15, 32'hFFFF_FFFF); // slot never used
    queue_handle_op(OP_PAUSE, 4'd1, 32'd2);
    queue_handle_op(OP_PAUSE, 4'd1, 32'd2);       // pause of a paused timer
    queue_advance(32'd0);
    queue_handle_op(OP_UNPAUSE, 4'd1, 32'd2);
    queue_handle_op(OP_UNPAUSE, 4'd1, 32'd2);     // unpause of a running timer
    queue_advance(32'd25);                        // late periodic rearm
    queue_handle_op(OP_QUERY, 4'd2, 32'd3);
    queue_handle_op(OP_CLEAR, 4'd2, 32'd3);
    queue_handle_op(OP_CLEAR, 4'd2, 32'd3);       // stale handle
    queue_cmd(blank_cmd(3'd7));
    for (int i = 0; i < 5; i++) queue_advance(32'hFFFF_FFFF); // drive time toward saturation
    queue_cmd(blank_cmd(OP_RESET));
    wait_drained();

    // Fill the table past full with due timers: the first advance reaches the firing cap.
    for (int i = 0; i < 17; i++) queue_add(32'd0, (i % 2) ? 32'd1 : 32'd0, i == 3);
    queue_advance(32'd1);
    queue_advance(32'd1);
    // Long receiver stall while the sender keeps offering.
    hold_rx = 1'b1;
    for (int i = 0; i < 10; i++) queue_advance(32'd1);
    wait_drained();
    hold_rx = 1'b0;
    queue_cmd(blank_cmd(OP_RESET));

    // Random part; the sender also pauses once until everything has drained.
    for (int i = 0; i < 150; i++) begin
      random_item();
      if (i == 70) begin
        wait_drained();
        tx_wait_drain = 1'b1;
      end
      if (i == 80) tx_wait_drain = 1'b0;
      if (i == 120) quiet = 1'b1;
      if (pending_cmds.size() > 8) wait_drained();
    end

    // Generation wrap is out of reach in a short run; the rest is drained here.
    wait_drained();
    repeat (200) @(posedge clk);
    if (!failed && expected_events.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/tqs_pkg.sv
rtl/tqs_stream_if.sv
rtl/tqs_mod_unit.sv
rtl/tqs_slot_ram.sv
rtl/timer_queue_scheduler.sv
bench/timer_queue_scheduler_test.sv
